// ----- src/rrba_pkg.sv -----
// shared types and constants for the rotating rectangle blit addresser
package rrba_pkg;

    // field widths
    localparam int COORD_W = 10;
    localparam int EXT_W   = 11;
    localparam int COLOR_W = 16;
    localparam int INDEX_W = 19;

    // command queue depth between front and back, a power of two
    localparam int QUEUE_DEPTH = 4;

    // operation codes
    localparam logic OP_OPEN  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // mode codes
    localparam logic [1:0] MODE_FILL   = 2'd0;
    localparam logic [1:0] MODE_COPY   = 2'd1;
    localparam logic [1:0] MODE_ROTATE = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BOUNDS = 3'd2,
        ST_TALL   = 3'd3,
        ST_IDLE   = 3'd4
    } status_t;

    // payload of one input beat, apart from the operation
    typedef struct packed {
        logic [1:0]         mode;
        logic [COORD_W-1:0] x_origin;
        logic [COORD_W-1:0] y_origin;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [COLOR_W-1:0] fill_color;
        logic [COLOR_W-1:0] pixel_value;
    } item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic               write;
        logic               last;
        status_t            status;
        logic [EXT_W-1:0]   mul_op;
        logic [EXT_W-1:0]   addend;
        logic [COLOR_W-1:0] data;
    } cmd_t;

endpackage

// ----- src/rrba_front.sv -----
// front end: checks opens, tracks the open rectangle and issues commands
module rrba_front #(
    parameter int PHYS_WIDTH       = 480,
    parameter int PHYS_HEIGHT      = 800,
    parameter int ROTATE_MAX_LINES = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_op,
    input  rrba_pkg::item_t in_item,
    input  logic            queue_full,
    output logic            push,
    output rrba_pkg::cmd_t  cmd
);
    import rrba_pkg::*;

    localparam logic [EXT_W-1:0] PW_C   = EXT_W'(PHYS_WIDTH);
    localparam logic [EXT_W-1:0] PH_C   = EXT_W'(PHYS_HEIGHT);
    localparam logic [EXT_W-1:0] ROT_C  = EXT_W'(ROTATE_MAX_LINES);
    localparam logic [EXT_W-1:0] PW_M1  = EXT_W'(PHYS_WIDTH - 1);

    logic               active_reg, active_next;
    logic [1:0]         mode_reg, mode_next;
    logic [COORD_W-1:0] ox_reg, ox_next;
    logic [COORD_W-1:0] oy_reg, oy_next;
    logic [COORD_W-1:0] width_reg, width_next;
    logic [COORD_W-1:0] height_reg, height_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;

    logic [EXT_W-1:0]   x_end, y_end, lim_x, lim_y;
    logic [EXT_W-1:0]   row_pos, col_pos;
    logic               col_wrap, row_wrap;
    status_t            open_status;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // open checks
    always_comb begin
        x_end = EXT_W'(in_item.x_origin) + EXT_W'(in_item.rect_width);
        y_end = EXT_W'(in_item.y_origin) + EXT_W'(in_item.rect_height);
        lim_x = (in_item.mode == MODE_ROTATE) ? PH_C : PW_C;
        lim_y = (in_item.mode == MODE_ROTATE) ? PW_C : PH_C;
        priority if (in_item.mode != MODE_FILL && in_item.mode != MODE_COPY &&
                     in_item.mode != MODE_ROTATE) begin
            open_status = ST_BOUNDS;
        end else if (in_item.rect_width == '0 || in_item.rect_height == '0) begin
            open_status = ST_EMPTY;
        end else if (x_end > lim_x || y_end > lim_y) begin
            open_status = ST_BOUNDS;
        end else if (in_item.mode == MODE_ROTATE &&
                     EXT_W'(in_item.rect_height) > ROT_C) begin
            open_status = ST_TALL;
        end else begin
            open_status = ST_OK;
        end
    end

    // pixel position and command build, plus next state
    always_comb begin
        row_pos  = EXT_W'(oy_reg) + EXT_W'(row_reg);
        col_pos  = EXT_W'(ox_reg) + EXT_W'(col_reg);
        col_wrap = (EXT_W'(col_reg) + EXT_W'(1)) >= EXT_W'(width_reg);
        row_wrap = (EXT_W'(row_reg) + EXT_W'(1)) >= EXT_W'(height_reg);

        active_next = active_reg;
        mode_next   = mode_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        width_next  = width_reg;
        height_next = height_reg;
        color_next  = color_reg;
        row_next    = row_reg;
        col_next    = col_reg;

        cmd        = '0;
        cmd.status = ST_OK;

        if (in_op == OP_OPEN) begin
            cmd.status = open_status;
            if (open_status == ST_OK) begin
                active_next = 1'b1;
                mode_next   = in_item.mode;
                ox_next     = in_item.x_origin;
                oy_next     = in_item.y_origin;
                width_next  = in_item.rect_width;
                height_next = in_item.rect_height;
                color_next  = in_item.fill_color;
                row_next    = '0;
                col_next    = '0;
            end else begin
                active_next = 1'b0;
            end
        end else if (!active_reg) begin
            cmd.status = ST_IDLE;
        end else begin
            cmd.write = 1'b1;
            if (mode_reg == MODE_ROTATE) begin
                cmd.mul_op = col_pos;
                cmd.addend = PW_M1 - row_pos;
            end else begin
                cmd.mul_op = row_pos;
                cmd.addend = col_pos;
            end
            cmd.data = (mode_reg == MODE_FILL) ? color_reg : in_item.pixel_value;
            if (col_wrap) begin
                col_next = '0;
                if (row_wrap) begin
                    cmd.last    = 1'b1;
                    active_next = 1'b0;
                    row_next    = '0;
                end else begin
                    row_next = row_reg + COORD_W'(1);
                end
            end else begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            mode_reg   <= MODE_FILL;
            row_reg    <= '0;
            col_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end else if (push) begin
            active_reg <= active_next;
            mode_reg   <= mode_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // held rectangle payload
    always_ff @(posedge aclk) begin
        if (push) begin
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            color_reg <= color_next;
        end
    end

    // the final write closes the rectangle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && cmd.last) |=> !active_reg)
        else $error("rectangle still open after its last write");

    // an open rectangle never has an empty size
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (width_reg != '0 && height_reg != '0))
        else $error("open rectangle with zero size");

    // column counter stays inside the row
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (col_reg < width_reg))
        else $error("column counter beyond rectangle width");

endmodule

// ----- src/rrba_queue.sv -----
// short command queue between front and back
module rrba_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rrba_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output rrba_pkg::cmd_t head_cmd
);
    import rrba_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (PTR_W+1)'(1);
            2'b01:   count_next = count_reg - (PTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // occupancy never exceeds the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("command queue overflow");

endmodule

// ----- src/rrba_back.sv -----
// back end: forms the framebuffer index and holds the result beat
module rrba_back #(
    parameter int PHYS_WIDTH = 480
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  rrba_pkg::cmd_t                 q_cmd,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_write,
    output logic [rrba_pkg::INDEX_W-1:0]   out_index,
    output logic [rrba_pkg::COLOR_W-1:0]   out_data,
    output logic                           out_last,
    output rrba_pkg::status_t              out_status
);
    import rrba_pkg::*;

    localparam logic [EXT_W-1:0] PW_C = EXT_W'(PHYS_WIDTH);

    logic                 a_valid_reg;
    cmd_t                 a_cmd_reg;
    logic [INDEX_W-1:0]   a_prod_reg;
    logic [2*EXT_W-1:0]   prod;

    logic                 o_valid_reg;
    logic                 o_write_reg;
    logic [INDEX_W-1:0]   o_index_reg, o_index_next;
    logic [COLOR_W-1:0]   o_data_reg;
    logic                 o_last_reg;
    status_t              o_status_reg;

    logic                 o_load, a_load;

    assign o_load = !o_valid_reg || out_ready;
    assign a_load = !a_valid_reg || o_load;
    assign q_pop  = q_valid && a_load;

    // row or column times the physical width
    assign prod         = (2*EXT_W)'(q_cmd.mul_op) * (2*EXT_W)'(PW_C);
    assign o_index_next = a_prod_reg + INDEX_W'(a_cmd_reg.addend);

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (a_load) a_valid_reg <= q_valid;
            if (o_load) o_valid_reg <= a_valid_reg;
        end
    end

    // product stage and output register payload
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_cmd_reg  <= q_cmd;
            a_prod_reg <= INDEX_W'(prod);
        end
        if (o_load) begin
            o_write_reg  <= a_cmd_reg.write;
            o_index_reg  <= o_index_next;
            o_data_reg   <= a_cmd_reg.data;
            o_last_reg   <= a_cmd_reg.last;
            o_status_reg <= a_cmd_reg.status;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_write  = o_write_reg;
    assign out_index  = o_index_reg;
    assign out_data   = o_data_reg;
    assign out_last   = o_last_reg;
    assign out_status = o_status_reg;

    // beats without a write carry zero payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (o_valid_reg && !o_write_reg) |->
            (o_index_reg == '0 && o_data_reg == '0 && !o_last_reg))
        else $error("non-write beat with nonzero payload");

endmodule

// ----- src/rotating_rect_blit_addresser.sv -----
// Rotating rectangle blit address engine for a portrait framebuffer. An open beat
// (tuser 0) checks and latches a rectangle; each pixel beat (tuser 1) produces one
// framebuffer write with its physical index, either at the same position or, in the
// rotated mode, with logical (lx, ly) mapped to physical (PHYS_WIDTH-1-ly, lx).
// Every input beat yields exactly one result beat. One beat per cycle is sustained while
// tready stays high; a result passes through the command queue entry, the product stage
// and the output register. The index multiplier in the back end is the one stage that
// sets this pipeline depth; a four-entry command queue lets input and output stall
// independently.
module rotating_rect_blit_addresser #(
    parameter int PHYS_WIDTH       = 480,
    parameter int PHYS_HEIGHT      = 800,
    parameter int ROTATE_MAX_LINES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode, x_origin, y_origin, rect_width, rect_height, fill_color, pixel_value
    input  logic [79:0] s_axis_tdata,
    // operation
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_index, pixel_data
    output logic [39:0] m_axis_tdata,
    // write_valid, status
    output logic [3:0]  m_axis_tuser,
    // last_pixel
    output logic        m_axis_tlast
);
    import rrba_pkg::*;

    item_t              item;
    cmd_t               push_cmd, head_cmd;
    logic               push, full, not_empty, pop;
    logic               out_write;
    logic [INDEX_W-1:0] out_index;
    logic [COLOR_W-1:0] out_data;
    status_t            out_status;

    // unpack the input beat
    assign item.mode        = s_axis_tdata[1:0];
    assign item.x_origin    = s_axis_tdata[11:2];
    assign item.y_origin    = s_axis_tdata[21:12];
    assign item.rect_width  = s_axis_tdata[31:22];
    assign item.rect_height = s_axis_tdata[41:32];
    assign item.fill_color  = s_axis_tdata[57:42];
    assign item.pixel_value = s_axis_tdata[73:58];

    rrba_front #(
        .PHYS_WIDTH       (PHYS_WIDTH),
        .PHYS_HEIGHT      (PHYS_HEIGHT),
        .ROTATE_MAX_LINES (ROTATE_MAX_LINES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_item    (item),
        .queue_full (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    rrba_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    rrba_back #(
        .PHYS_WIDTH (PHYS_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (not_empty),
        .q_cmd      (head_cmd),
        .q_pop      (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_write  (out_write),
        .out_index  (out_index),
        .out_data   (out_data),
        .out_last   (m_axis_tlast),
        .out_status (out_status)
    );

    // pack the result beat
    assign m_axis_tdata = {5'b0, out_data, out_index};
    assign m_axis_tuser = {out_status, out_write};

endmodule

// ----- sim/tb_rotating_rect_blit_addresser.sv -----
// self-checking testbench for the rotating rectangle blit addresser
`timescale 1ns / 1ps

module tb_rotating_rect_blit_addresser;
    import rrba_pkg::*;

    localparam int PW         = 480;
    localparam int PH         = 800;
    localparam int MAX_LINES  = 64;
    localparam int RAND_BEATS = 450;

    // one framebuffer result as seen on the master side
    typedef struct {
        logic               wr;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] data;
        logic               last;
        status_t            status;
    } blit_write_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // mode, x_origin, y_origin, rect_width, rect_height, fill_color, pixel_value
    logic [79:0] s_axis_tdata  = '0;
    // operation
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // pixel_index, pixel_data
    logic [39:0] m_axis_tdata;
    // write_valid, status
    logic [3:0]  m_axis_tuser;
    // last_pixel
    logic        m_axis_tlast;

    // predictor state
    logic               rect_open;
    logic [1:0]         held_mode;
    logic [9:0]         held_x, held_y, held_w, held_h;
    logic [COLOR_W-1:0] held_color;
    logic [9:0]         row_pos, col_pos;

    blit_write_t pending_writes[$];
    int          errors     = 0;
    int          beats_sent = 0;
    bit          no_idle    = 1'b0;

    rotating_rect_blit_addresser #(
        .PHYS_WIDTH      (PW),
        .PHYS_HEIGHT     (PH),
        .ROTATE_MAX_LINES(MAX_LINES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // 12 ns clock
    always #6 aclk = ~aclk;

    // open checks: mode code, then size, then bounds, then rotated line limit
    function automatic status_t check_rect(logic [1:0] md, int x, int y, int w, int h);
        int lim_x;
        int lim_y;
        lim_x = PW;
        lim_y = PH;
        if (md > MODE_ROTATE) return ST_BOUNDS;
        if (w == 0 || h == 0) return ST_EMPTY;
        if (md == MODE_ROTATE) begin
            lim_x = PH;
            lim_y = PW;
        end
        if (x + w > lim_x || y + h > lim_y) return ST_BOUNDS;
        if (md == MODE_ROTATE && h > MAX_LINES) return ST_TALL;
        return ST_OK;
    endfunction

    // expected result of one accepted beat, advancing the predictor state
    function automatic blit_write_t predict_blit_write(logic op, logic [79:0] d);
        blit_write_t res;
        logic [1:0]  md;
        logic [31:0] r, c, idx;
        md = d[1:0];
        res = '{wr: 1'b0, index: '0, data: '0, last: 1'b0, status: ST_OK};
        if (op == OP_OPEN) begin
            res.status = check_rect(md, int'(d[11:2]), int'(d[21:12]), int'(d[31:22]),
                                    int'(d[41:32]));
            if (res.status == ST_OK) begin
                rect_open  = 1'b1;
                held_mode  = md;
                held_x     = d[11:2];
                held_y     = d[21:12];
                held_w     = d[31:22];
                held_h     = d[41:32];
                held_color = d[57:42];
                row_pos    = '0;
                col_pos    = '0;
            end else begin
                rect_open = 1'b0;
            end
        end else if (!rect_open) begin
            res.status = ST_IDLE;
        end else begin
            r = 32'(held_y) + 32'(row_pos);
            c = 32'(held_x) + 32'(col_pos);
            res.wr = 1'b1;
            if (held_mode == MODE_ROTATE) idx = c * PW + (PW - 1 - r);
            else                         idx = r * PW + c;
            res.index = idx[INDEX_W-1:0];
            res.data  = (held_mode == MODE_FILL) ? held_color : d[73:58];
            // row-major walk over the source rectangle
            if (32'(col_pos) + 1 >= 32'(held_w)) begin
                col_pos = '0;
                if (32'(row_pos) + 1 >= 32'(held_h)) begin
                    res.last  = 1'b1;
                    rect_open = 1'b0;
                    row_pos   = '0;
                end else begin
                    row_pos = row_pos + 10'd1;
                end
            end else begin
                col_pos = col_pos + 10'd1;
            end
        end
        return res;
    endfunction

    // drive one beat at the falling edge and hold it until accepted
    task automatic send_beat(input logic op, input logic [1:0] md,
                             input logic [9:0] x, input logic [9:0] y,
                             input logic [9:0] w, input logic [9:0] h,
                             input logic [15:0] fc, input logic [15:0] pv);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {6'd0, pv, fc, h, w, y, x, md};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_writes.push_back(predict_blit_write(op, s_axis_tdata));
        beats_sent++;
    endtask

    task automatic send_open(input logic [1:0] md, input int x, input int y,
                             input int w, input int h, input logic [15:0] fc);
        send_beat(OP_OPEN, md, 10'(x), 10'(y), 10'(w), 10'(h), fc, 16'($urandom));
    endtask

    // pixel beat with junk in the open-only fields
    task automatic send_pixel(input logic [15:0] pv);
        send_beat(OP_PIXEL, 2'($urandom), 10'($urandom), 10'($urandom),
                  10'($urandom), 10'($urandom), 16'($urandom), pv);
    endtask

    task automatic send_pixels(input int n);
        repeat (n) send_pixel(16'($urandom));
    endtask

    // pixel with nothing open, all field bits set and then clear
    task automatic test_idle_pixel();
        send_beat(OP_PIXEL, 2'b11, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 16'hffff, 16'hffff);
        send_beat(OP_PIXEL, 2'b00, 10'h000, 10'h000, 10'h000, 10'h000, 16'h0000, 16'h0000);
    endtask

    // every reject status, then a pixel that must find nothing open
    task automatic test_open_rejects();
        send_open(MODE_COPY, 0, 0, 0, 4, 16'h1234);
        send_open(MODE_FILL, 0, 0, 4, 0, 16'h1234);
        send_open(2'd3, 0, 0, 1, 1, 16'h1234);
        send_open(MODE_COPY, 470, 0, 20, 1, 16'h1234);
        send_open(MODE_ROTATE, 0, 470, 2, 20, 16'h1234);
        send_open(MODE_ROTATE, 0, 0, 2, MAX_LINES + 1, 16'h1234);
        send_beat(OP_OPEN, MODE_ROTATE, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 16'hffff, 16'h0);
        send_pixel(16'hbeef);
    endtask

    // fill at the bottom right corner of the panel
    task automatic test_fill();
        send_open(MODE_FILL, PW - 2, PH - 1, 2, 1, 16'hffff);
        send_pixels(2);
    endtask

    // copy, and an open that replaces a partly written rectangle
    task automatic test_copy();
        send_open(MODE_COPY, 0, 0, 3, 1, 16'h0);
        send_pixels(3);
        send_open(MODE_COPY, 10, 10, 2, 2, 16'h0);
        send_pixel(16'h0000);
        send_open(MODE_COPY, 5, 7, 1, 1, 16'h0);
        send_pixel(16'hffff);
    endtask

    // rotated copy at the far logical corner
    task automatic test_rotate();
        send_open(MODE_ROTATE, PH - 2, PW - 2, 2, 2, 16'h0);
        send_pixels(4);
    endtask

    // mostly well-formed rectangles, some broken ones and noise
    task automatic test_random();
        int start;
        int pick, md, w, h, lim_x, lim_y, x, y, n;
        start = beats_sent;
        while (beats_sent - start < RAND_BEATS) begin
            no_idle = (beats_sent - start > 150 && beats_sent - start < 230);
            pick = $urandom_range(99);
            if (pick < 70) begin
                md = $urandom_range(2);
                w  = $urandom_range(1, 6);
                h  = $urandom_range(1, 5);
                if ($urandom_range(19) == 0) begin
                    w = 1;
                    h = (md == MODE_ROTATE) ? MAX_LINES : $urandom_range(10, 30);
                end
                lim_x = (md == MODE_ROTATE) ? PH : PW;
                lim_y = (md == MODE_ROTATE) ? PW : PH;
                x = ($urandom_range(3) == 0) ? lim_x - w : $urandom_range(lim_x - w);
                y = ($urandom_range(3) == 0) ? lim_y - h : $urandom_range(lim_y - h);
                if ($urandom_range(3) == 0) x = 0;
                send_open(2'(md), x, y, w, h, 16'($urandom));
                n = w * h;
                if ($urandom_range(6) == 0) n = $urandom_range(n - 1);
                send_pixels(n);
                if ($urandom_range(9) == 0) send_pixel(16'($urandom));
            end else if (pick < 85) begin
                send_beat(OP_OPEN, 2'($urandom), 10'($urandom), 10'($urandom),
                          10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom));
                send_pixels($urandom_range(0, 2));
            end else if (pick < 95) begin
                // rotated heights around the line limit
                h = $urandom_range(MAX_LINES - 2, MAX_LINES + 3);
                send_open(MODE_ROTATE, $urandom_range(PH - 1), 0, 1, h, 16'($urandom));
                send_pixels($urandom_range(0, 3));
            end else begin
                send_pixel(16'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // result side backpressure
    always @(negedge aclk) begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        blit_write_t exp_w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_writes.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_w = pending_writes.pop_front();
                if (m_axis_tuser[0] !== exp_w.wr) begin
                    $error("write_valid: expected %0d, got %0d", exp_w.wr, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[3:1] !== exp_w.status) begin
                    $error("status: expected %0d, got %0d", exp_w.status, m_axis_tuser[3:1]);
                    errors++;
                end
                if (m_axis_tdata[18:0] !== exp_w.index) begin
                    $error("pixel_index: expected %0d, got %0d", exp_w.index,
                           m_axis_tdata[18:0]);
                    errors++;
                end
                if (m_axis_tdata[34:19] !== exp_w.data) begin
                    $error("pixel_data: expected %h, got %h", exp_w.data, m_axis_tdata[34:19]);
                    errors++;
                end
                if (m_axis_tlast !== exp_w.last) begin
                    $error("last_pixel: expected %0d, got %0d", exp_w.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial begin
        #3_000_000;
        $display("rotating_rect_blit_addresser regression: fail");
        $finish;
    end

    initial begin
        int waited;
        rect_open  = 1'b0;
        held_mode  = '0;
        held_x     = '0;
        held_y     = '0;
        held_w     = '0;
        held_h     = '0;
        held_color = '0;
        row_pos    = '0;
        col_pos    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_pixel();
        test_open_rejects();
        test_fill();
        test_copy();
        test_rotate();
        test_random();

        @(negedge aclk);
        s_axis_tvalid = 1'b0;

        // drain, then let the pipeline settle
        waited = 0;
        while (pending_writes.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_writes.size() != 0) begin
            $error("%0d expected results never arrived", pending_writes.size());
            errors++;
        end
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("rotating_rect_blit_addresser regression: pass");
        end else begin
            $display("rotating_rect_blit_addresser regression: fail");
        end
        $finish;
    end

endmodule
